### src/tvsc_pkg.sv
// Shared types, codes, mode tables and helper functions of the sound carrier autodetect block.
package tvsc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_LEVEL   = 3'd1;
  localparam logic [2:0] KIND_STEREO  = 3'd2;
  localparam logic [2:0] KIND_NICAM   = 3'd3;
  localparam logic [2:0] KIND_REQUEST = 3'd4;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_LEVEL  = 2'd1;
  localparam logic [1:0] ACT_STEREO = 2'd2;
  localparam logic [1:0] ACT_NICAM  = 2'd3;

  localparam logic TGT_DEM = 1'b0;
  localparam logic TGT_DFP = 1'b1;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_MAIN       = 3'd1;
  localparam logic [2:0] PH_SUB        = 3'd2;
  localparam logic [2:0] PH_WAIT_FM    = 3'd3;
  localparam logic [2:0] PH_WAIT_NICAM = 3'd4;

  localparam logic [2:0] DM_AM    = 3'd0;
  localparam logic [2:0] DM_TERRA = 3'd3;
  localparam logic [2:0] DM_NICAM = 3'd5;

  localparam logic [1:0] SM_MONO   = 2'd0;
  localparam logic [1:0] SM_STEREO = 2'd1;
  localparam logic [1:0] SM_LANG1  = 2'd2;
  localparam logic [1:0] SM_LANG2  = 2'd3;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_VOLUME    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NICAM_CAP = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIO     = 2'd2;

  // Program segments, emitted in this order.
  localparam int NUM_SEGS = 8;
  localparam int SEG_W    = 3;
  localparam logic [SEG_W-1:0] SEG_VOL0   = 3'd0;
  localparam logic [SEG_W-1:0] SEG_MODEA  = 3'd1;
  localparam logic [SEG_W-1:0] SEG_CARA   = 3'd2;
  localparam logic [SEG_W-1:0] SEG_STEREO = 3'd3;
  localparam logic [SEG_W-1:0] SEG_MODEB  = 3'd4;
  localparam logic [SEG_W-1:0] SEG_CARB   = 3'd5;
  localparam logic [SEG_W-1:0] SEG_VOLE   = 3'd6;
  localparam logic [SEG_W-1:0] SEG_AWAIT  = 3'd7;
  localparam int STEP_W = 5;

  localparam logic [1:0] TAB_AM    = 2'd0;
  localparam logic [1:0] TAB_TERRA = 2'd1;
  localparam logic [1:0] TAB_NICAM = 2'd2;

  localparam int CDO_W = 23;
  localparam logic [CDO_W-1:0] CDO_55   = 23'd5006222;
  localparam logic [CDO_W-1:0] CDO_5742 = 23'd5226666;
  localparam logic [CDO_W-1:0] CDO_585  = 23'd5324800;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] reading;
    logic [1:0]         stereo_request;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        target;
    logic [7:0]  reg_addr;
    logic [15:0] reg_value;
    logic [1:0]  sound_mode;
    logic        last;
  } out_word_t;

  // One input's program of result words, expanded by the back end.
  typedef struct packed {
    logic [NUM_SEGS-1:0] segs;
    logic                mode_terra;
    logic [CDO_W-1:0]    cdo;
    logic                st_nicam;
    logic [1:0]          st_mode;
    logic [6:0]          vol;
    logic                nicam_cap;
    logic [1:0]          await_act;
    logic [1:0]          sound_mode;
  } desc_t;

  typedef struct packed {
    logic        tgt;
    logic [7:0]  addr;
    logic [15:0] value;
  } item_t;

  function automatic logic [CDO_W-1:0] main_cdo(input logic [1:0] i);
    logic [CDO_W-1:0] c;
    case (i)
      2'd0:    c = 23'd4096000;
      2'd1:    c = 23'd5006222;
      2'd2:    c = 23'd5461333;
      default: c = 23'd5916444;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] sub_count(input logic [1:0] bmi);
    logic [1:0] n;
    if (bmi == 2'd1) n = 2'd2;
    else if (bmi == 2'd3) n = 2'd3;
    else n = 2'd0;
    return n;
  endfunction

  function automatic logic [CDO_W-1:0] sub_cdo(input logic [1:0] bmi, input logic [1:0] i);
    logic [CDO_W-1:0] c;
    if (bmi == 2'd1) begin
      c = i[0] ? 23'd5324800 : 23'd5226666;
    end else begin
      case (i)
        2'd1:    c = 23'd6553600;
        2'd2:    c = 23'd6717440;
        default: c = 23'd6389760;
      endcase
    end
    return c;
  endfunction

  // volume * 0x73 / 65535, via a shift by 16 and one correction step.
  function automatic logic [6:0] vol_scale(input logic [15:0] v);
    logic [22:0] x;
    logic [6:0]  q0;
    logic [16:0] r;
    x  = 23'(v) * 23'd115;
    q0 = x[22:16];
    r  = {1'b0, x[15:0]} + 17'(q0);
    if (r >= 17'd65535) return q0 + 7'd1;
    return q0;
  endfunction

  function automatic item_t carrier_item(input logic [1:0] k, input logic [CDO_W-1:0] c1,
                                         input logic [CDO_W-1:0] c2);
    item_t it;
    it.tgt = TGT_DEM;
    case (k)
      2'd0: begin it.addr = 8'h93; it.value = {4'b0, c1[11:0]}; end
      2'd1: begin it.addr = 8'h9b; it.value = {5'b0, c1[22:12]}; end
      2'd2: begin it.addr = 8'ha3; it.value = {4'b0, c2[11:0]}; end
      default: begin it.addr = 8'hab; it.value = {5'b0, c2[22:12]}; end
    endcase
    return it;
  endfunction

  // Filter coefficients; second selects the second channel's set (distinct only for NICAM).
  function automatic logic [15:0] mode_coef(input logic [1:0] tab, input logic second,
                                            input logic [2:0] i);
    logic [15:0] c;
    if (tab == TAB_AM) begin
      case (i)
        3'd0: c = 16'd75;
        3'd1: c = 16'd19;
        3'd2: c = 16'd36;
        3'd3: c = 16'd35;
        3'd4: c = 16'd39;
        default: c = 16'd40;
      endcase
    end else if (tab == TAB_NICAM && !second) begin
      case (i)
        3'd0: c = 16'hfffe;
        3'd1: c = 16'hfff8;
        3'd2: c = 16'hfff6;
        3'd3: c = 16'd10;
        3'd4: c = 16'd50;
        default: c = 16'd86;
      endcase
    end else begin
      case (i)
        3'd0: c = 16'd3;
        3'd1: c = 16'd18;
        3'd2: c = 16'd27;
        3'd3: c = 16'd48;
        3'd4: c = 16'd66;
        default: c = 16'd72;
      endcase
    end
    return c;
  endfunction

  function automatic item_t mode_item(input logic [1:0] tab, input logic [STEP_W-1:0] step);
    item_t       it;
    logic [4:0]  t;
    logic [15:0] src;
    logic [15:0] mreg;
    t  = 5'd0;
    it = '0;
    case (tab)
      TAB_TERRA: begin src = 16'h0030; mreg = 16'h0480; end
      TAB_NICAM: begin src = 16'h0120; mreg = 16'h0040; end
      default:   begin src = 16'h0020; mreg = 16'h0500; end
    endcase
    if (step == 5'd0) begin
      it = '{TGT_DEM, 8'hbb, 16'h00d0};
    end else if (step <= 5'd6) begin
      t  = 5'd6 - step;
      it = '{TGT_DEM, 8'h01, mode_coef(tab, 1'b0, t[2:0])};
    end else if (step == 5'd7) begin
      it = '{TGT_DEM, 8'h05, 16'h0004};
    end else if (step == 5'd8) begin
      it = '{TGT_DEM, 8'h05, 16'h0040};
    end else if (step == 5'd9) begin
      it = '{TGT_DEM, 8'h05, 16'h0000};
    end else if (step <= 5'd15) begin
      t  = 5'd15 - step;
      it = '{TGT_DEM, 8'h05, mode_coef(tab, 1'b1, t[2:0])};
    end else if (step == 5'd16) begin
      it = '{TGT_DEM, 8'h83, mreg};
    end else if (step <= 5'd20) begin
      t  = step - 5'd17;
      it = carrier_item(t[1:0], CDO_55, CDO_55);
    end else if (step == 5'd21) begin
      it = '{TGT_DFP, 8'h08, src};
    end else if (step == 5'd22) begin
      it = '{TGT_DFP, 8'h09, src};
    end else if (step == 5'd23) begin
      it = '{TGT_DFP, 8'h0a, src};
    end else if (step == 5'd24) begin
      it = '{TGT_DFP, 8'h0e, 16'h3000};
    end else begin
      it = '{TGT_DFP, 8'h10, 16'h3000};
    end
    return it;
  endfunction

endpackage

### src/tvsc_front.sv
// Front end: configuration registers, detection state and translation of each input word
// into a program descriptor.
module tvsc_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tvsc_pkg::in_word_t                 in_data,
  input  logic                               cfg_we,
  input  logic [tvsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [tvsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               q_full,
  output logic                               q_push,
  output tvsc_pkg::desc_t                    q_desc
);

  logic [15:0]        volume_r;
  logic               nicap_r;
  logic               radio_r;
  logic [2:0]         phase_r, phase_nxt;
  logic [2:0]         demod_r, demod_nxt;
  logic [1:0]         stereo_r, stereo_nxt;
  logic [1:0]         scan_r, scan_nxt;
  logic signed [15:0] bml_r, bml_nxt;
  logic [1:0]         bmi_r, bmi_nxt;
  logic signed [15:0] bsl_r, bsl_nxt;
  logic [1:0]         bsi_r, bsi_nxt;

  logic               in_fire;
  logic               do_finish;
  logic               do_stereo;
  logic               check;
  logic [1:0]         st_m;
  logic signed [15:0] rd;
  logic [3:0]         nic_s;
  tvsc_pkg::desc_t    d;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !q_full;
  assign q_desc   = d;

  always_comb begin
    phase_nxt  = phase_r;
    demod_nxt  = demod_r;
    stereo_nxt = stereo_r;
    scan_nxt   = scan_r;
    bml_nxt    = bml_r;
    bmi_nxt    = bmi_r;
    bsl_nxt    = bsl_r;
    bsi_nxt    = bsi_r;
    q_push     = 1'b0;
    do_finish  = 1'b0;
    do_stereo  = 1'b0;
    check      = 1'b0;
    st_m       = in_data.stereo_request;
    rd         = in_data.reading;
    nic_s      = rd[4:1];
    d          = '0;
    d.nicam_cap = nicap_r;

    if (in_fire) begin
      if (in_data.kind == tvsc_pkg::KIND_START) begin
        if (!radio_r) begin
          d.segs[tvsc_pkg::SEG_VOL0]  = 1'b1;
          d.segs[tvsc_pkg::SEG_MODEA] = 1'b1;
          d.segs[tvsc_pkg::SEG_CARA]  = 1'b1;
          d.segs[tvsc_pkg::SEG_AWAIT] = 1'b1;
          d.mode_terra = 1'b0;
          d.cdo        = tvsc_pkg::main_cdo(2'd0);
          d.vol        = 7'd0;
          d.await_act  = tvsc_pkg::ACT_LEVEL;
          demod_nxt    = tvsc_pkg::DM_AM;
          stereo_nxt   = tvsc_pkg::SM_MONO;
          bml_nxt      = '0;
          bmi_nxt      = '0;
          bsl_nxt      = '0;
          bsi_nxt      = '0;
          scan_nxt     = '0;
          phase_nxt    = tvsc_pkg::PH_MAIN;
          q_push       = 1'b1;
        end
      end else if (in_data.kind == tvsc_pkg::KIND_LEVEL && phase_r == tvsc_pkg::PH_MAIN) begin
        if (bml_r < rd) begin
          bml_nxt = rd;
          bmi_nxt = scan_r;
        end
        if (scan_r != 2'd3) begin
          scan_nxt = scan_r + 2'd1;
          d.segs[tvsc_pkg::SEG_CARA]  = 1'b1;
          d.segs[tvsc_pkg::SEG_AWAIT] = 1'b1;
          d.cdo       = tvsc_pkg::main_cdo(scan_r + 2'd1);
          d.await_act = tvsc_pkg::ACT_LEVEL;
          q_push      = 1'b1;
        end else if (tvsc_pkg::sub_count(bmi_nxt) != 2'd0) begin
          scan_nxt  = '0;
          phase_nxt = tvsc_pkg::PH_SUB;
          d.segs[tvsc_pkg::SEG_CARA]  = 1'b1;
          d.segs[tvsc_pkg::SEG_AWAIT] = 1'b1;
          d.cdo       = tvsc_pkg::sub_cdo(bmi_nxt, 2'd0);
          d.await_act = tvsc_pkg::ACT_LEVEL;
          q_push      = 1'b1;
        end else begin
          scan_nxt  = '0;
          do_finish = 1'b1;
        end
      end else if (in_data.kind == tvsc_pkg::KIND_LEVEL && phase_r == tvsc_pkg::PH_SUB) begin
        if (bsl_r < rd) begin
          bsl_nxt = rd;
          bsi_nxt = scan_r;
        end
        if ({1'b0, scan_r} + 3'd1 < {1'b0, tvsc_pkg::sub_count(bmi_r)}) begin
          scan_nxt = scan_r + 2'd1;
          d.segs[tvsc_pkg::SEG_CARA]  = 1'b1;
          d.segs[tvsc_pkg::SEG_AWAIT] = 1'b1;
          d.cdo       = tvsc_pkg::sub_cdo(bmi_r, scan_r + 2'd1);
          d.await_act = tvsc_pkg::ACT_LEVEL;
          q_push      = 1'b1;
        end else begin
          scan_nxt  = '0;
          do_finish = 1'b1;
        end
      end else if (in_data.kind == tvsc_pkg::KIND_STEREO &&
                   phase_r == tvsc_pkg::PH_WAIT_FM) begin
        phase_nxt = tvsc_pkg::PH_IDLE;
        do_stereo = 1'b1;
        if (rd > 16'sd4096) st_m = tvsc_pkg::SM_STEREO;
        else if (rd < -16'sd4096) st_m = tvsc_pkg::SM_LANG1;
        else st_m = tvsc_pkg::SM_MONO;
      end else if (in_data.kind == tvsc_pkg::KIND_NICAM &&
                   phase_r == tvsc_pkg::PH_WAIT_NICAM) begin
        phase_nxt = tvsc_pkg::PH_IDLE;
        do_stereo = 1'b1;
        st_m = (nic_s == 4'd0 || nic_s == 4'd8) ? tvsc_pkg::SM_STEREO : tvsc_pkg::SM_MONO;
      end else if (in_data.kind == tvsc_pkg::KIND_REQUEST) begin
        do_stereo = 1'b1;
      end
    end

    // End of the scan: terrestrial FM first, then the stereo or NICAM choice.
    if (do_finish) begin
      d.segs[tvsc_pkg::SEG_MODEA] = 1'b1;
      d.segs[tvsc_pkg::SEG_CARA]  = 1'b1;
      d.segs[tvsc_pkg::SEG_VOLE]  = 1'b1;
      d.mode_terra = 1'b1;
      d.cdo        = tvsc_pkg::main_cdo(bmi_nxt);
      d.vol        = tvsc_pkg::vol_scale(volume_r);
      demod_nxt    = tvsc_pkg::DM_TERRA;
      stereo_nxt   = tvsc_pkg::SM_MONO;
      if (!bmi_nxt[1]) begin
        if (bsi_nxt == 2'd0) begin
          d.segs[tvsc_pkg::SEG_STEREO] = 1'b1;
          d.st_nicam = 1'b0;
          d.st_mode  = tvsc_pkg::SM_MONO;
          check      = 1'b1;
        end else if (bsi_nxt == 2'd1 && nicap_r) begin
          d.segs[tvsc_pkg::SEG_MODEB] = 1'b1;
          d.segs[tvsc_pkg::SEG_CARB]  = 1'b1;
          demod_nxt = tvsc_pkg::DM_NICAM;
          check     = 1'b1;
        end
      end else begin
        d.segs[tvsc_pkg::SEG_STEREO] = 1'b1;
        d.st_nicam = 1'b0;
        d.st_mode  = tvsc_pkg::SM_STEREO;
        stereo_nxt = tvsc_pkg::SM_STEREO;
      end
      if (check) begin
        d.segs[tvsc_pkg::SEG_AWAIT] = 1'b1;
        if (demod_nxt == tvsc_pkg::DM_TERRA) begin
          d.await_act = tvsc_pkg::ACT_STEREO;
          phase_nxt   = tvsc_pkg::PH_WAIT_FM;
        end else begin
          d.await_act = tvsc_pkg::ACT_NICAM;
          phase_nxt   = tvsc_pkg::PH_WAIT_NICAM;
        end
      end else begin
        phase_nxt = tvsc_pkg::PH_IDLE;
      end
      q_push = 1'b1;
    end

    // A sound mode change only means something in an FM or NICAM mode.
    if (do_stereo && (demod_r == tvsc_pkg::DM_TERRA || demod_r == tvsc_pkg::DM_NICAM)) begin
      d.segs[tvsc_pkg::SEG_STEREO] = 1'b1;
      d.st_nicam = (demod_r == tvsc_pkg::DM_NICAM);
      d.st_mode  = st_m;
      stereo_nxt = st_m;
      q_push     = 1'b1;
    end

    d.sound_mode = stereo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= 16'hffff;
      nicap_r  <= 1'b0;
      radio_r  <= 1'b0;
      phase_r  <= tvsc_pkg::PH_IDLE;
      demod_r  <= tvsc_pkg::DM_AM;
      stereo_r <= tvsc_pkg::SM_MONO;
      scan_r   <= '0;
      bml_r    <= '0;
      bmi_r    <= '0;
      bsl_r    <= '0;
      bsi_r    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == tvsc_pkg::REG_VOLUME) volume_r <= cfg_wdata;
        if (cfg_addr == tvsc_pkg::REG_NICAM_CAP) nicap_r <= cfg_wdata[0];
        if (cfg_addr == tvsc_pkg::REG_RADIO) radio_r <= cfg_wdata[0];
      end
      phase_r  <= phase_nxt;
      demod_r  <= demod_nxt;
      stereo_r <= stereo_nxt;
      scan_r   <= scan_nxt;
      bml_r    <= bml_nxt;
      bmi_r    <= bmi_nxt;
      bsl_r    <= bsl_nxt;
      bsi_r    <= bsi_nxt;
    end
  end

endmodule

### src/tvsc_queue.sv
// Short descriptor queue between the front end and the write sequencer.
module tvsc_queue #(
  parameter int Depth = tvsc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tvsc_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output tvsc_pkg::desc_t head_desc
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  tvsc_pkg::desc_t entry_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full       = (count_r == CntW'(Depth));
  assign head_valid = (count_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

### src/tvsc_back.sv
// Back end: walks the segments of the head descriptor and emits one result word per cycle unless stalled.
module tvsc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  tvsc_pkg::desc_t      head_desc,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tvsc_pkg::out_word_t  out_data
);

  logic [tvsc_pkg::SEG_W-1:0]  seg_r, seg_nxt;
  logic [tvsc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  tvsc_pkg::out_word_t         out_r;

  logic [tvsc_pkg::SEG_W-1:0]  cur;
  logic                        more;
  logic                        seg_done;
  logic                        fire;
  logic [tvsc_pkg::STEP_W-1:0] step_inc;
  logic [tvsc_pkg::STEP_W-1:0] mode_last;
  logic [15:0]                 vol_val;
  logic [15:0]                 src;
  tvsc_pkg::item_t             it;
  logic [1:0]                  act;
  tvsc_pkg::desc_t             d;

  assign d         = head_desc;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fire      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = fire && seg_done && !more;

  // First enabled segment at or after the current one, and whether any follows it.
  always_comb begin
    cur  = '0;
    more = 1'b0;
    for (int i = tvsc_pkg::NUM_SEGS - 1; i >= 0; i--) begin
      if (d.segs[i] && tvsc_pkg::SEG_W'(i) >= seg_r) cur = tvsc_pkg::SEG_W'(i);
    end
    for (int i = 0; i < tvsc_pkg::NUM_SEGS; i++) begin
      if (d.segs[i] && tvsc_pkg::SEG_W'(i) > cur) more = 1'b1;
    end
  end

  always_comb begin
    mode_last = d.nicam_cap ? 5'd25 : 5'd24;
    vol_val   = {1'b0, d.vol, 8'h00};
    src       = d.st_nicam ? 16'h0100 : 16'h0000;
    if (d.st_mode == tvsc_pkg::SM_STEREO) src = src | 16'h0020;
    else if (d.st_mode == tvsc_pkg::SM_LANG2) src = src | 16'h0010;
    act       = tvsc_pkg::ACT_WRITE;
    it        = '0;
    seg_done  = 1'b0;
    step_inc  = step_r + 1'b1;
    unique case (cur)
      tvsc_pkg::SEG_VOL0, tvsc_pkg::SEG_VOLE: begin
        seg_done = (step_r == 5'd2);
        if (step_r == 5'd0) it = '{tvsc_pkg::TGT_DFP, 8'h00, vol_val};
        else if (step_r == 5'd1) it = '{tvsc_pkg::TGT_DFP, 8'h06, vol_val};
        else it = '{tvsc_pkg::TGT_DFP, 8'h07, (d.vol != 7'd0) ? 16'h4000 : 16'h0000};
      end
      tvsc_pkg::SEG_MODEA: begin
        seg_done = (step_r == mode_last);
        it = tvsc_pkg::mode_item(d.mode_terra ? tvsc_pkg::TAB_TERRA : tvsc_pkg::TAB_AM,
                                 step_r);
      end
      tvsc_pkg::SEG_MODEB: begin
        seg_done = (step_r == mode_last);
        it = tvsc_pkg::mode_item(tvsc_pkg::TAB_NICAM, step_r);
      end
      tvsc_pkg::SEG_CARA: begin
        seg_done = (step_r == 5'd3);
        it = tvsc_pkg::carrier_item(step_r[1:0], d.cdo, d.cdo);
      end
      tvsc_pkg::SEG_CARB: begin
        seg_done = (step_r == 5'd3);
        it = tvsc_pkg::carrier_item(step_r[1:0], tvsc_pkg::CDO_585, tvsc_pkg::CDO_55);
      end
      tvsc_pkg::SEG_STEREO: begin
        // NICAM skips the matrix write; only stereo ends with the extra enable write.
        seg_done = (step_r == 5'd8) ||
                   (step_r == 5'd7 && d.st_mode != tvsc_pkg::SM_STEREO);
        if (step_r == 5'd3 && d.st_nicam) step_inc = 5'd5;
        if (step_r <= 5'd3) begin
          it = tvsc_pkg::carrier_item(step_r[1:0],
                                      d.st_nicam ? tvsc_pkg::CDO_585 : tvsc_pkg::CDO_5742,
                                      tvsc_pkg::CDO_55);
        end else if (step_r == 5'd4) begin
          it = '{tvsc_pkg::TGT_DFP, 8'h0e,
                 (d.st_mode == tvsc_pkg::SM_STEREO) ? 16'h3001 : 16'h3000};
        end else if (step_r == 5'd5) begin
          it = '{tvsc_pkg::TGT_DFP, 8'h08, src};
        end else if (step_r == 5'd6) begin
          it = '{tvsc_pkg::TGT_DFP, 8'h09, src};
        end else if (step_r == 5'd7) begin
          it = '{tvsc_pkg::TGT_DFP, 8'h0a, src};
        end else begin
          it = '{tvsc_pkg::TGT_DFP, 8'h05, 16'h4000};
        end
      end
      tvsc_pkg::SEG_AWAIT: begin
        seg_done = 1'b1;
        act      = d.await_act;
        if (d.await_act == tvsc_pkg::ACT_LEVEL) it = '{tvsc_pkg::TGT_DFP, 8'h1b, 16'h0000};
        else if (d.await_act == tvsc_pkg::ACT_STEREO) it = '{tvsc_pkg::TGT_DFP, 8'h18, 16'h0000};
        else it = '{tvsc_pkg::TGT_DEM, 8'h23, 16'h0000};
      end
    endcase
  end

  always_comb begin
    seg_nxt  = seg_r;
    step_nxt = step_r;
    if (fire) begin
      if (seg_done) begin
        seg_nxt  = more ? cur + 1'b1 : '0;
        step_nxt = '0;
      end else begin
        step_nxt = step_inc;
      end
    end
    if (fire) out_valid_nxt = 1'b1;
    else out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.action     <= act;
      out_r.target     <= it.tgt;
      out_r.reg_addr   <= it.addr;
      out_r.reg_value  <= it.value;
      out_r.sound_mode <= d.sound_mode;
      out_r.last       <= seg_done && !more;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/tv_sound_carrier_autodetect_core.sv
// Top level of the sound carrier autodetect controller: front end, descriptor queue, sequencer.
//
//   Channel   Direction  Handshake            Word
//   in_       input      in_valid / in_stall   tvsc_pkg::in_word_t (kind, reading, request)
//   out_      output     out_valid / out_stall tvsc_pkg::out_word_t (one register action)
//   cfg_      input      cfg_we                register index cfg_addr, data cfg_wdata
//
// Each accepted word turns into 0 to 64 result words, emitted one per cycle by the sequencer
// as long as the output is not stalled.
// The front end takes a new word every cycle while the two-entry descriptor queue has room,
// so the sustained rate is set by the sequencer's one-word-per-cycle output.
// Reset is synchronous and active low; it clears the detection state and the queue and
// loads the register defaults (full volume, no NICAM, not in radio).
// A stall on the output holds the output register and, once the queue fills, stalls the input.
module tv_sound_carrier_autodetect_core #(
  parameter int QueueDepth = tvsc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tvsc_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tvsc_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [tvsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tvsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_head_valid;
  tvsc_pkg::desc_t q_push_desc;
  tvsc_pkg::desc_t q_head_desc;

  // The front end holds all detection state and decides, per word, which groups of
  // register writes are due and what the sound mode will be afterwards.
  tvsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_push_desc)
  );

  // The queue decouples the two sides so a stalled output does not block the next input.
  tvsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (q_push_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_desc  (q_head_desc)
  );

  // The sequencer expands one descriptor into its register writes and, where it has one, the
  // final await request, marking the last word of each program.
  tvsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_desc  (q_head_desc),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

### src/tvsc_checker.sv
// Port-level checks of the sound carrier autodetect controller and their bind.
module tvsc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tvsc_pkg::out_word_t out_data
);

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output word changed while stalled");

  a_await_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != tvsc_pkg::ACT_WRITE |->
      out_data.last && out_data.reg_value == 16'h0000)
    else $error("await request is not the final word or carries a value");

  a_level_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == tvsc_pkg::ACT_LEVEL |->
      out_data.target == tvsc_pkg::TGT_DFP && out_data.reg_addr == 8'h1b)
    else $error("level request names the wrong register");

endmodule

bind tv_sound_carrier_autodetect_core tvsc_checker u_tvsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
